/* design/msp_frame_parser_defines.svh */
// Assertion helpers shared by the frame parser modules.
`ifndef MSP_FRAME_PARSER_DEFINES_SVH
`define MSP_FRAME_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/msp_pkg.sv */
package msp_pkg;

   // Framing characters.
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;

   // Role register values.
   localparam logic ROLE_CLIENT = 1'b0;
   localparam logic ROLE_SERVER = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_SUM_GOOD = 2'd1;
   localparam logic [1:0] KIND_SUM_BAD  = 2'd2;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PRE  = 3'd1,
      PH_DIR  = 3'd2,
      PH_LEN  = 3'd3,
      PH_CMD  = 3'd4,
      PH_DATA = 3'd5,
      PH_SUM  = 3'd6
   } phase_type;

   // One result item as it travels from the parser core to the output register.
   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] message_id;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_length;
   } msp_result_type;

endpackage

/* design/msp_parse_core.sv */
`include "msp_frame_parser_defines.svh"

module msp_parse_core
   import msp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write,
   input  logic           csr_role,
   input  logic           byte_valid,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   output msp_result_type result
);

   phase_type  phase_ff, phase_in;
   logic       role_ff, role_in;
   logic [7:0] declared_length_ff, declared_length_in;
   logic [7:0] message_code_ff, message_code_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic [7:0] received_count_ff, received_count_in;
   logic [7:0] xor_next;
   logic [7:0] count_next;
   logic       dir_ok;

   assign xor_next   = running_xor_ff ^ rx_byte;
   assign count_next = received_count_ff + 8'd1;
   assign dir_ok     = ((rx_byte == CH_GT) && (role_ff == ROLE_CLIENT)) ||
                       ((rx_byte == CH_LT) && (role_ff == ROLE_SERVER));

   // Role register; a new role takes effect at the next direction byte.
   assign role_in = csr_write ? csr_role : role_ff;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PH_IDLE: phase_in = (rx_byte == CH_DOLLAR) ? PH_PRE : PH_IDLE;
            PH_PRE:  phase_in = (rx_byte == CH_M) ? PH_DIR : PH_IDLE;
            PH_DIR:  phase_in = dir_ok ? PH_LEN : PH_IDLE;
            PH_LEN:  phase_in = PH_CMD;
            PH_CMD:  phase_in = (declared_length_ff != 8'd0) ? PH_DATA : PH_SUM;
            PH_DATA: phase_in = (count_next >= declared_length_ff) ? PH_SUM : PH_DATA;
            PH_SUM:  phase_in = PH_IDLE;
            default: phase_in = (rx_byte == CH_DOLLAR) ? PH_PRE : PH_IDLE;
         endcase
      end
   end

   // Frame fields, checksum and payload counter.
   always_comb begin
      declared_length_in = declared_length_ff;
      message_code_in    = message_code_ff;
      running_xor_in     = running_xor_ff;
      received_count_in  = received_count_ff;
      if (step) begin
         case (phase_ff)
            PH_LEN: begin
               running_xor_in     = rx_byte;
               declared_length_in = rx_byte;
               received_count_in  = 8'd0;
            end
            PH_CMD: begin
               running_xor_in  = xor_next;
               message_code_in = rx_byte;
            end
            PH_DATA: begin
               running_xor_in    = xor_next;
               received_count_in = count_next;
            end
            PH_SUM: begin
               running_xor_in = xor_next;
            end
            default: begin
               running_xor_in = running_xor_ff;
            end
         endcase
      end
   end

   // Result for the byte held in the input register.
   always_comb begin
      result.valid        = 1'b0;
      result.kind         = KIND_PAYLOAD;
      result.message_id   = message_code_ff;
      result.payload_byte = 8'd0;
      result.byte_index   = 8'd0;
      result.frame_length = declared_length_ff;
      case (phase_ff)
         PH_DATA: begin
            result.valid        = byte_valid;
            result.payload_byte = rx_byte;
            result.byte_index   = received_count_ff;
         end
         PH_SUM: begin
            result.valid = byte_valid;
            result.kind  = (xor_next == 8'd0) ? KIND_SUM_GOOD : KIND_SUM_BAD;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         role_ff            <= ROLE_CLIENT;
         declared_length_ff <= 8'd0;
         message_code_ff    <= 8'd0;
         running_xor_ff     <= 8'd0;
         received_count_ff  <= 8'd0;
      end else begin
         phase_ff           <= phase_in;
         role_ff            <= role_in;
         declared_length_ff <= declared_length_in;
         message_code_ff    <= message_code_in;
         running_xor_ff     <= running_xor_in;
         received_count_ff  <= received_count_in;
      end
   end

   // The payload counter never passes the declared length.
   `MSP_ASSERT_NEXT(a_count_bound, clock, reset, step && (phase_ff == PH_DATA),
      received_count_ff <= declared_length_ff, "payload count passed declared length")
   // Results come only from payload and checksum bytes.
   `MSP_ASSERT_SAME(a_result_phase, clock, reset, result.valid,
      (phase_ff == PH_DATA) || (phase_ff == PH_SUM), "result outside payload or checksum")
   // A checksum byte always closes the frame.
   `MSP_ASSERT_NEXT(a_sum_closes, clock, reset, step && (phase_ff == PH_SUM),
      phase_ff == PH_IDLE, "parser did not return to hunting after checksum")

endmodule

/* design/msp_out_reg.sv */
module msp_out_reg
   import msp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  msp_result_type result,
   input  logic           rsp_stall,
   output logic           free,
   output logic           rsp_valid,
   output logic [1:0]     rsp_kind,
   output logic [7:0]     rsp_message_id,
   output logic [7:0]     rsp_payload_byte,
   output logic [7:0]     rsp_byte_index,
   output logic [7:0]     rsp_frame_length
);

   logic           valid_ff, valid_in;
   msp_result_type data_ff, data_in;

   // The register can take a new result when empty or when its result leaves now.
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (free) begin
         valid_in = load;
         if (load) begin
            data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = data_ff.kind;
   assign rsp_message_id   = data_ff.message_id;
   assign rsp_payload_byte = data_ff.payload_byte;
   assign rsp_byte_index   = data_ff.byte_index;
   assign rsp_frame_length = data_ff.frame_length;

endmodule

/* design/msp_frame_parser.sv */
// Frame parser for the MultiWii serial protocol, version 1.
// Request channel: one received byte per request on req_rx_byte, taken at a
// clock edge with req_valid high and req_stall low.
// Response channel: payload bytes with their index, then one frame-end
// response per frame carrying the command, declared length and checksum verdict.
// A response is taken at an edge with rsp_valid high and rsp_stall low.
// Bytes that fall outside a frame produce no response.
// csr_role selects which direction character is accepted: 0 client ('>'),
// 1 server ('<'); it is written when csr_valid is high, csr_ready is always high.
// Responses are held in the output register. Throughput: one request per cycle
// unless the receiver stalls, set by the single pass from the input register
// through the parser state machine into the output register.
// When the receiver stalls, the output register holds its response and the
// input register keeps taking a request; req_stall rises once the input
// register holds a byte that cannot move on.
// Reset clears both registers, sets the role to client and resumes hunting for '$'.
`include "msp_frame_parser_defines.svh"

module msp_frame_parser
   import msp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_message_id,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_byte_index,
   output logic [7:0] rsp_frame_length,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_role
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           advance;
   logic           in_free;
   logic           out_free;
   msp_result_type result;

   assign csr_ready = 1'b1;

   // The held byte moves on unless its response finds the output register busy.
   assign advance   = in_valid_ff && (!result.valid || out_free);
   assign in_free   = !in_valid_ff || advance;
   assign req_stall = !in_free;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (in_free) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_byte_in = req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   msp_parse_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_role   (csr_role),
      .byte_valid (in_valid_ff),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .result     (result)
   );

   msp_out_reg u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (advance && result.valid),
      .result           (result),
      .rsp_stall        (rsp_stall),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_message_id   (rsp_message_id),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length)
   );

   // Stall is raised only while a byte waits for a busy output register.
   `MSP_ASSERT_SAME(a_stall_cause, clock, reset, req_stall,
      in_valid_ff && result.valid && rsp_valid && rsp_stall, "stall without a blocked response")
   // A response never carries an unused kind code.
   `MSP_ASSERT_SAME(a_kind_code, clock, reset, rsp_valid,
      (rsp_kind == KIND_PAYLOAD) || (rsp_kind == KIND_SUM_GOOD) || (rsp_kind == KIND_SUM_BAD),
      "response with unused kind code")

endmodule

/* test/tb_msp_frame_parser.sv */
`timescale 1ns / 100ps

module tb_msp_frame_parser;
   import msp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // One response as seen on the rsp_ port group.
   typedef struct {
      logic [1:0] kind;
      logic [7:0] message_id;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_length;
   } parser_rsp_type;

   // Tracks the parser's framing state and the responses it still owes.
   class frame_checker;
      logic           role;
      phase_type      parse_phase;
      logic [7:0]     len_q;
      logic [7:0]     cmd_q;
      logic [7:0]     sum_q;
      logic [7:0]     count_q;
      parser_rsp_type awaited_q[$];
      int             mismatches;
      int             response_count;
      int             payload_count;
      int             good_frames;
      int             bad_frames;

      function new();
         role           = ROLE_CLIENT;
         parse_phase    = PH_IDLE;
         len_q          = 8'h00;
         cmd_q          = 8'h00;
         sum_q          = 8'h00;
         count_q        = 8'h00;
         mismatches     = 0;
         response_count = 0;
         payload_count  = 0;
         good_frames    = 0;
         bad_frames     = 0;
      endfunction

      function void set_role(logic r);
         role = r;
      endfunction

      function int pending();
         return awaited_q.size();
      endfunction

      // Advance the framing state by one accepted request byte.
      function void take_byte(logic [7:0] b);
         parser_rsp_type r;
         r.payload_byte = 8'h00;
         r.byte_index   = 8'h00;
         case (parse_phase)
            PH_PRE: begin
               parse_phase = (b == CH_M) ? PH_DIR : PH_IDLE;
            end
            PH_DIR: begin
               if ((b == CH_GT && role == ROLE_CLIENT) || (b == CH_LT && role == ROLE_SERVER))
                  parse_phase = PH_LEN;
               else
                  parse_phase = PH_IDLE;
            end
            PH_LEN: begin
               sum_q       = b;
               len_q       = b;
               count_q     = 8'h00;
               parse_phase = PH_CMD;
            end
            PH_CMD: begin
               sum_q       = sum_q ^ b;
               cmd_q       = b;
               parse_phase = (len_q != 8'h00) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
               sum_q          = sum_q ^ b;
               r.kind         = KIND_PAYLOAD;
               r.message_id   = cmd_q;
               r.payload_byte = b;
               r.byte_index   = count_q;
               r.frame_length = len_q;
               awaited_q.push_back(r);
               payload_count++;
               count_q = count_q + 8'd1;
               if (count_q >= len_q)
                  parse_phase = PH_SUM;
            end
            PH_SUM: begin
               sum_q          = sum_q ^ b;
               r.kind         = (sum_q == 8'h00) ? KIND_SUM_GOOD : KIND_SUM_BAD;
               r.message_id   = cmd_q;
               r.frame_length = len_q;
               awaited_q.push_back(r);
               if (sum_q == 8'h00)
                  good_frames++;
               else
                  bad_frames++;
               parse_phase = PH_IDLE;
            end
            default: begin
               parse_phase = (b == CH_DOLLAR) ? PH_PRE : PH_IDLE;
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("MISMATCH at %0t ns: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
         if (got_v !== want_v)
            report_mismatch($sformatf("response %0d field %s: got %02h, wanted %02h",
                                      response_count, name, got_v, want_v));
      endtask

      // Compare one accepted response with the oldest awaited one.
      task check_response(parser_rsp_type got);
         parser_rsp_type want;
         response_count++;
         if (awaited_q.size() == 0) begin
            report_mismatch($sformatf("response %0d not expected: kind %0d id %02h",
                                      response_count, got.kind, got.message_id));
            return;
         end
         want = awaited_q.pop_front();
         compare_field("kind", 8'(got.kind), 8'(want.kind));
         compare_field("message_id", got.message_id, want.message_id);
         compare_field("payload_byte", got.payload_byte, want.payload_byte);
         compare_field("byte_index", got.byte_index, want.byte_index);
         compare_field("frame_length", got.frame_length, want.frame_length);
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_message_id;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_byte_index;
   logic [7:0] rsp_frame_length;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_role = 1'b0;

   frame_checker frames = new();
   int   cycle_count   = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   frame_items   = 0;
   logic role_setting  = ROLE_CLIENT;

   msp_frame_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_message_id   (rsp_message_id),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_role         (csr_role)
   );

   always #2 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, frames.pending());
         $display("status: fail");
         $finish;
      end
   end

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Sample both handshakes on the edge that completes them.
   always @(posedge clock) begin
      parser_rsp_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.kind         = rsp_kind;
            got.message_id   = rsp_message_id;
            got.payload_byte = rsp_payload_byte;
            got.byte_index   = rsp_byte_index;
            got.frame_length = rsp_frame_length;
            frames.check_response(got);
         end
         if (req_valid && !req_stall)
            frames.take_byte(req_rx_byte);
      end
   end

   // Present one request byte, after a random gap, and hold it until taken.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stop requests and wait until every awaited response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (frames.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_role(input logic r);
      csr_valid <= 1'b1;
      csr_role  <= r;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      frames.set_role(r);
      role_setting = r;
   endtask

   // Send one frame, usually well formed, sometimes broken on purpose.
   task automatic send_frame(input bit skip_preamble, input int forced_len);
      logic [7:0] frame_q[$];
      logic [7:0] len_b;
      logic [7:0] cmd_b;
      logic [7:0] sum_b;
      logic [7:0] b;
      int         sel;
      int         n;
      sel = $urandom_range(99);
      if (forced_len >= 0)
         n = forced_len;
      else if (sel < 85)
         n = $urandom_range(8);
      else if (sel < 97)
         n = $urandom_range(40, 9);
      else
         n = $urandom_range(255, 41);
      len_b = 8'(n);
      cmd_b = 8'($urandom);
      sum_b = len_b ^ cmd_b;

      // Preamble, now and then with a wrong second character.
      if (!skip_preamble) begin
         frame_q.push_back(CH_DOLLAR);
         if ($urandom_range(99) < 4)
            frame_q.push_back(8'($urandom));
         else
            frame_q.push_back(CH_M);
      end

      // Direction: mostly the one for the current role.
      sel = $urandom_range(99);
      if (sel < 5)
         frame_q.push_back((role_setting == ROLE_SERVER) ? CH_GT : CH_LT);
      else if (sel < 7)
         frame_q.push_back(8'($urandom));
      else
         frame_q.push_back((role_setting == ROLE_SERVER) ? CH_LT : CH_GT);

      frame_q.push_back(len_b);
      frame_q.push_back(cmd_b);
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         sum_b = sum_b ^ b;
         frame_q.push_back(b);
      end
      if ($urandom_range(99) < 10)
         sum_b = sum_b ^ 8'($urandom_range(255, 1));
      frame_q.push_back(sum_b);

      // Occasionally cut the frame short.
      if ($urandom_range(99) < 3) begin
         sel = $urandom_range(frame_q.size() - 1, 1);
         while (frame_q.size() > sel)
            void'(frame_q.pop_back());
      end

      foreach (frame_q[i])
         send_byte(frame_q[i]);
      frame_items += frame_q.size();
   endtask

   initial begin
      int   goal;
      logic phase_role;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero length frame with a good checksum, client role from reset.
      send_byte(CH_DOLLAR);
      send_byte(CH_M);
      send_byte(CH_GT);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      // A server direction character is refused by a client.
      send_byte(CH_DOLLAR);
      send_byte(CH_M);
      send_byte(CH_LT);
      // A second dollar where 'M' belongs restarts the hunt and is not reused.
      send_byte(CH_DOLLAR);
      send_byte(CH_DOLLAR);
      send_byte(CH_M);
      send_byte(CH_GT);
      // Two payload bytes at both extremes, then a bad checksum.
      send_byte(CH_DOLLAR);
      send_byte(CH_M);
      send_byte(CH_GT);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      drain();

      // Random phases with different idle mixes and roles.
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 10;
               rsp_stall_pct = 54;
               phase_role    = ROLE_SERVER;
            end
            1: begin
               send_idle_pct = 54;
               rsp_stall_pct = 10;
               phase_role    = ROLE_CLIENT;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               phase_role    = ROLE_SERVER;
            end
         endcase
         write_role(phase_role);

         // The previous phase left the parser waiting for a direction byte.
         if (ph > 0)
            send_frame(1'b1, -1);
         if (ph == 0)
            send_frame(1'b0, 255);

         goal = frame_items + 100;
         while (frame_items < goal) begin
            if ($urandom_range(99) < 15)
               repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            send_frame(1'b0, -1);
         end

         // Stop mid-frame so the next role applies at the next direction byte.
         send_byte(CH_DOLLAR);
         send_byte(CH_M);
         drain();
      end

      if (frames.pending() != 0)
         frames.report_mismatch($sformatf("%0d responses never arrived", frames.pending()));

      $display("Checked %0d responses: %0d payload bytes, %0d good and %0d bad frame ends.",
               frames.response_count, frames.payload_count, frames.good_frames,
               frames.bad_frames);
      $display("Both roles, broken preambles and directions, and all idle mixes were run.");
      if (frames.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
